// ----- src/lcal_pkg.sv -----
// ----------------------------------------------------------------------------
// lcal_pkg
// Shared types and constants for the binary-lifting common ancestor engine.
// ----------------------------------------------------------------------------
package lcal_pkg;

	// Field widths fixed by the interface
	localparam int NODE_W  = 10;
	localparam int DEPTH_W = 10;
	localparam int COUNT_W = 11;
	localparam int ENTRY_W = NODE_W + 1;

	// Jump entry with the top bit set marks "no ancestor"
	localparam logic [ENTRY_W-1:0] NO_ANC = {1'b1, {NODE_W{1'b0}}};

	// Node count after reset
	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

	// Request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLD_MID,
		ST_BLD_UP,
		ST_BLD_WR,
		ST_Q_SWAP,
		ST_Q_LIFT,
		ST_Q_CMP,
		ST_Q_JOINT,
		ST_Q_PAR,
		ST_Q_RES,
		ST_Q_OUT
	} state_t;

	// One input transaction
	typedef struct packed {
		logic               req_type;
		logic [NODE_W-1:0]  node_a;
		logic [NODE_W-1:0]  node_b;
		logic               has_parent;
		logic [DEPTH_W-1:0] node_depth;
		logic               last_load;
	} req_t;

	// One result transaction
	typedef struct packed {
		logic [NODE_W-1:0] common_ancestor;
		logic              ancestor_is_endpoint;
	} res_t;

endpackage

// ----- src/lcal_ram.sv -----
// ----------------------------------------------------------------------------
// lcal_ram
// Synchronous RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module lcal_ram #(
	parameter int WIDTH  = 11,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	output logic [WIDTH-1:0]  rdata_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read ports, registered read data
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ----- src/lcal_seq.sv -----
// ----------------------------------------------------------------------------
// lcal_seq
// Sequencer and datapath: node loads, level-by-level jump table build, and
// the two lifting passes of a query, all around the jump and depth RAMs.
// ----------------------------------------------------------------------------
module lcal_seq #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lcal_pkg::COUNT_W-1:0] node_count,
	input  lcal_pkg::req_t               req,
	input  logic                         req_take,
	output logic                         idle,
	output lcal_pkg::res_t               res,
	output logic                         res_valid,
	input  logic                         res_ready
);

	localparam int AW     = $clog2(MAX_NODES);
	localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int JAW    = LW + AW;
	localparam int JDEPTH = LEVELS * (1 << AW);
	localparam logic [16:0] MAXN = 17'(MAX_NODES);
	localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);
	localparam int NW = lcal_pkg::NODE_W;
	localparam int EW = lcal_pkg::ENTRY_W;

	function automatic logic in_range(input logic [NW-1:0] n);
		in_range = 17'(n) < MAXN;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] n);
		logic [16:0] e;
		e = 17'(n);
		addr_of = e[AW-1:0];
	endfunction

	function automatic logic entry_real(input logic [EW-1:0] e);
		entry_real = !e[EW-1] && in_range(e[NW-1:0]);
	endfunction

	lcal_pkg::state_t state_q, state_d;

	logic [LW-1:0]               lvl_q;
	logic [AW-1:0]               idx_q;
	logic [NW-1:0]               u_q, v_q, qa_q, qb_q;
	logic [lcal_pkg::DEPTH_W-1:0] diff_q;
	logic                        mid_real_q;
	logic                        oka_s1, okb_s1;
	logic                        lift_pend_s1, joint_pend_s1;
	lcal_pkg::res_t              res_q;

	logic           j_we;
	logic [JAW-1:0] j_waddr, j_ra, j_rb;
	logic [EW-1:0]  j_wdata, j_rda, j_rdb;
	logic           d_we;
	logic [AW-1:0]  d_waddr, d_ra, d_rb;
	logic [lcal_pkg::DEPTH_W-1:0] d_wdata, d_rda, d_rdb;

	logic [16:0] cnt_ext, cnt_lim;
	logic        idx_last, lvl_last, build_go, take_load, take_query;
	logic        ea_real, eb_real, move;
	logic [NW-1:0] u_now, v_now;
	logic [lcal_pkg::DEPTH_W-1:0] da, db, diff_sh;
	logic        diff_bit;

	lcal_ram #(
		.WIDTH  (EW),
		.DEPTH  (JDEPTH),
		.ADDR_W (JAW)
	) u_jump_ram (
		.clk     (clk),
		.we      (j_we),
		.waddr   (j_waddr),
		.wdata   (j_wdata),
		.raddr_a (j_ra),
		.rdata_a (j_rda),
		.raddr_b (j_rb),
		.rdata_b (j_rdb)
	);

	lcal_ram #(
		.WIDTH  (lcal_pkg::DEPTH_W),
		.DEPTH  (MAX_NODES),
		.ADDR_W (AW)
	) u_depth_ram (
		.clk     (clk),
		.we      (d_we),
		.waddr   (d_waddr),
		.wdata   (d_wdata),
		.raddr_a (d_ra),
		.rdata_a (d_rda),
		.raddr_b (d_rb),
		.rdata_b (d_rdb)
	);

	// Build bounds and transaction decode
	always_comb begin
		cnt_ext    = 17'(node_count);
		cnt_lim    = (cnt_ext > MAXN) ? MAXN : cnt_ext;
		idx_last   = (17'(idx_q) + 17'd1) == cnt_lim;
		lvl_last   = lvl_q == LVL_TOP;
		take_load  = req_take && (req.req_type == lcal_pkg::REQ_LOAD);
		take_query = req_take && (req.req_type == lcal_pkg::REQ_QUERY);
		build_go   = take_load && req.last_load && (cnt_lim != 17'd0) && (LEVELS > 1);
	end

	// Resolve the reads issued last cycle and forward the moved nodes
	always_comb begin
		ea_real = oka_s1 && entry_real(j_rda);
		eb_real = okb_s1 && entry_real(j_rdb);
		move    = joint_pend_s1 && ea_real && eb_real && (j_rda[NW-1:0] != j_rdb[NW-1:0]);
		u_now   = ((lift_pend_s1 && ea_real) || move) ? j_rda[NW-1:0] : u_q;
		v_now   = move ? j_rdb[NW-1:0] : v_q;
		da      = oka_s1 ? d_rda : '0;
		db      = okb_s1 ? d_rdb : '0;
		diff_sh = diff_q >> lvl_q;
		diff_bit = diff_sh[0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcal_pkg::ST_IDLE: begin
				if (take_query) begin
					state_d = lcal_pkg::ST_Q_SWAP;
				end else if (build_go) begin
					state_d = lcal_pkg::ST_BLD_MID;
				end
			end
			lcal_pkg::ST_BLD_MID: state_d = lcal_pkg::ST_BLD_UP;
			lcal_pkg::ST_BLD_UP:  state_d = lcal_pkg::ST_BLD_WR;
			lcal_pkg::ST_BLD_WR: begin
				state_d = (idx_last && lvl_last) ? lcal_pkg::ST_IDLE : lcal_pkg::ST_BLD_MID;
			end
			lcal_pkg::ST_Q_SWAP: state_d = lcal_pkg::ST_Q_LIFT;
			lcal_pkg::ST_Q_LIFT: begin
				if (lvl_q == '0) begin
					state_d = lcal_pkg::ST_Q_CMP;
				end
			end
			lcal_pkg::ST_Q_CMP: begin
				state_d = (u_now == v_q) ? lcal_pkg::ST_Q_OUT : lcal_pkg::ST_Q_JOINT;
			end
			lcal_pkg::ST_Q_JOINT: begin
				if (lvl_q == '0) begin
					state_d = lcal_pkg::ST_Q_PAR;
				end
			end
			lcal_pkg::ST_Q_PAR: state_d = lcal_pkg::ST_Q_RES;
			lcal_pkg::ST_Q_RES: state_d = lcal_pkg::ST_Q_OUT;
			lcal_pkg::ST_Q_OUT: begin
				if (res_ready) begin
					state_d = lcal_pkg::ST_IDLE;
				end
			end
			default: state_d = lcal_pkg::ST_IDLE;
		endcase
	end

	// Memory ports and handshake outputs
	always_comb begin
		idle      = 1'b0;
		res_valid = 1'b0;
		res       = res_q;
		j_we      = 1'b0;
		j_waddr   = {lvl_q, idx_q};
		j_wdata   = lcal_pkg::NO_ANC;
		j_ra      = {lvl_q, addr_of(u_now)};
		j_rb      = {lvl_q, addr_of(v_now)};
		d_we      = 1'b0;
		d_waddr   = addr_of(req.node_a);
		d_wdata   = req.node_depth;
		d_ra      = addr_of(req.node_a);
		d_rb      = addr_of(req.node_b);
		unique case (state_q)
			lcal_pkg::ST_IDLE: begin
				idle = 1'b1;
				// Level zero holds the parent
				if (take_load && in_range(req.node_a)) begin
					j_we    = 1'b1;
					j_waddr = {LW'(0), addr_of(req.node_a)};
					j_wdata = req.has_parent ? {1'b0, req.node_b} : lcal_pkg::NO_ANC;
					d_we    = 1'b1;
				end
			end
			lcal_pkg::ST_BLD_MID: j_ra = {lvl_q - LW'(1), idx_q};
			lcal_pkg::ST_BLD_UP:  j_ra = {lvl_q - LW'(1), addr_of(j_rda[NW-1:0])};
			lcal_pkg::ST_BLD_WR: begin
				j_we    = 1'b1;
				j_wdata = (mid_real_q && entry_real(j_rda)) ? j_rda : lcal_pkg::NO_ANC;
			end
			lcal_pkg::ST_Q_PAR: j_rb = {LW'(0), addr_of(v_now)};
			lcal_pkg::ST_Q_OUT: res_valid = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lcal_pkg::ST_IDLE;
			lvl_q         <= '0;
			idx_q         <= '0;
			lift_pend_s1  <= 1'b0;
			joint_pend_s1 <= 1'b0;
		end else begin
			state_q       <= state_d;
			lift_pend_s1  <= 1'b0;
			joint_pend_s1 <= 1'b0;
			case (state_q)
				lcal_pkg::ST_IDLE: begin
					if (build_go) begin
						lvl_q <= LW'(1);
						idx_q <= '0;
					end
				end
				lcal_pkg::ST_BLD_WR: begin
					// Advance to the next node, or the next level
					if (idx_last) begin
						idx_q <= '0;
						lvl_q <= lvl_q + LW'(1);
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				lcal_pkg::ST_Q_SWAP, lcal_pkg::ST_Q_CMP: lvl_q <= LVL_TOP;
				lcal_pkg::ST_Q_LIFT: begin
					lift_pend_s1 <= diff_bit;
					if (lvl_q != '0) begin
						lvl_q <= lvl_q - LW'(1);
					end
				end
				lcal_pkg::ST_Q_JOINT: begin
					joint_pend_s1 <= 1'b1;
					if (lvl_q != '0) begin
						lvl_q <= lvl_q - LW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			lcal_pkg::ST_IDLE: begin
				qa_q   <= req.node_a;
				qb_q   <= req.node_b;
				u_q    <= req.node_a;
				v_q    <= req.node_b;
				oka_s1 <= in_range(req.node_a);
				okb_s1 <= in_range(req.node_b);
			end
			lcal_pkg::ST_BLD_UP: mid_real_q <= entry_real(j_rda);
			lcal_pkg::ST_Q_SWAP: begin
				// Put the deeper node in u
				if (da < db) begin
					u_q    <= qb_q;
					v_q    <= qa_q;
					diff_q <= db - da;
				end else begin
					diff_q <= da - db;
				end
			end
			lcal_pkg::ST_Q_LIFT: begin
				u_q    <= u_now;
				oka_s1 <= in_range(u_now);
			end
			lcal_pkg::ST_Q_CMP: begin
				u_q <= u_now;
				res_q.common_ancestor      <= u_now;
				res_q.ancestor_is_endpoint <= (u_now == qa_q) || (u_now == qb_q);
			end
			lcal_pkg::ST_Q_JOINT: begin
				u_q    <= u_now;
				v_q    <= v_now;
				oka_s1 <= in_range(u_now);
				okb_s1 <= in_range(v_now);
			end
			lcal_pkg::ST_Q_PAR: begin
				u_q    <= u_now;
				v_q    <= v_now;
				okb_s1 <= in_range(v_now);
			end
			lcal_pkg::ST_Q_RES: begin
				// Drop to zero when the trees differ
				res_q.common_ancestor      <= eb_real ? j_rdb[NW-1:0] : '0;
				res_q.ancestor_is_endpoint <= eb_real &&
					((j_rdb[NW-1:0] == qa_q) || (j_rdb[NW-1:0] == qb_q));
			end
			default: ;
		endcase
	end

endmodule

// ----- src/lowest_common_ancestor_lifting_top.sv -----
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting_top
// Lowest common ancestor engine over a loaded tree using binary lifting.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A load is written while idle; a load
// marked last then builds the jump table, (LEVELS - 1) * min(node_count,
// MAX_NODES) entries, each through ST_BLD_MID, ST_BLD_UP and ST_BLD_WR, set by
// the dependent pair of reads from the single jump RAM. A query steps from
// acceptance to result through one jump RAM read per level for the depth lift
// and, unless one node is an ancestor of the other, one dual-port read per
// level for the joint lift, each read's data steering the next address. The
// result waits in an output register, and the next transaction is taken the
// cycle after a result moves there, so a new query waits for the last result.
// Jump and depth RAMs are not cleared at reset.
module lowest_common_ancestor_lifting_top #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [lcal_pkg::NODE_W-1:0]   node_a,
	input  logic [lcal_pkg::NODE_W-1:0]   node_b,
	input  logic                          has_parent,
	input  logic [lcal_pkg::DEPTH_W-1:0]  node_depth,
	input  logic                          last_load,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lcal_pkg::NODE_W-1:0]   common_ancestor,
	output logic                          ancestor_is_endpoint,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lcal_pkg::COUNT_W-1:0]  cfg_data
);

	logic [lcal_pkg::COUNT_W-1:0] node_count_q;
	lcal_pkg::req_t req;
	lcal_pkg::res_t res, res_q;
	logic seq_idle, res_valid, res_ready, out_valid_q;

	// Node count register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= lcal_pkg::NODE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// Pack the input transaction
	always_comb begin
		req.req_type   = req_type;
		req.node_a     = node_a;
		req.node_b     = node_b;
		req.has_parent = has_parent;
		req.node_depth = node_depth;
		req.last_load  = last_load;
	end

	assign in_stall = !seq_idle;

	lcal_seq #(
		.MAX_NODES (MAX_NODES),
		.LEVELS    (LEVELS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.req        (req),
		.req_take   (in_valid && !in_stall),
		.idle       (seq_idle),
		.res        (res),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

	// Output register: load a new result, hold while stalled
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid            = out_valid_q;
	assign common_ancestor      = res_q.common_ancestor;
	assign ancestor_is_endpoint = res_q.ancestor_is_endpoint;

endmodule
